[sv/affi_pkg.sv]
package affi_pkg;

  localparam int AW   = 32;
  localparam int PW   = 2 * AW;
  localparam int ADJW = PW + 1;
  localparam int PRW  = AW + 33;
  localparam int DETW = ADJW + AW + 2;
  localparam int QB   = 33;
  localparam int THRW = 31;

  localparam logic [1:0] ROW0 = 2'd0;
  localparam logic [1:0] ROW1 = 2'd1;
  localparam logic [1:0] ROW2 = 2'd2;
  localparam logic [1:0] ROW_LAST = ROW2;

  // adjugate entry k = a[i0]*a[i1] - a[i2]*a[i3], row-major entry index
  localparam int ADJ_IDX [0:8][0:3] = '{
    '{4, 8, 7, 5}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 6, 4}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  typedef logic signed [AW-1:0] word_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] row;
  } ctl_t;

endpackage

[sv/affi_front.sv]
module affi_front
  import affi_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ctl_t                         ctl_i,
  input  word_t                        a_i [9],
  input  word_t                        t_i [3],
  input  logic [THRW-1:0]              thr_i,
  output ctl_t                         ctl_o,
  output logic                         sing_o,
  output logic [DETW-1:0]              d_o,
  output logic [ADJW+2*FRAC_BITS-1:0]  n_o [3],
  output logic [1:0]                   tag_o [3],
  output word_t                        t_o [3]
);

  localparam int NW = ADJW + 2 * FRAC_BITS;
  localparam int CW = DETW + QB;

  ctl_t ctl_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) ctl_q[i] <= '0;
    end else begin
      ctl_q[0] <= ctl_i;
      for (int i = 1; i < 6; i++) ctl_q[i] <= ctl_q[i-1];
    end
  end

  // stage 1: cofactor products
  logic signed [PW-1:0] pa_q [9];
  logic signed [PW-1:0] pb_q [9];
  word_t a0_q [3];
  word_t t1_q [3];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 9; k++) begin
      pa_q[k] <= PW'(a_i[ADJ_IDX[k][0]]) * PW'(a_i[ADJ_IDX[k][1]]);
      pb_q[k] <= PW'(a_i[ADJ_IDX[k][2]]) * PW'(a_i[ADJ_IDX[k][3]]);
    end
    for (int j = 0; j < 3; j++) begin
      a0_q[j] <= a_i[j];
      t1_q[j] <= t_i[j];
    end
  end

  // stage 2: adjugate
  logic signed [ADJW-1:0] adj_q [9];
  word_t a0b_q [3];
  word_t t2_q [3];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 9; k++) adj_q[k] <= ADJW'(pa_q[k]) - ADJW'(pb_q[k]);
    for (int j = 0; j < 3; j++) begin
      a0b_q[j] <= a0_q[j];
      t2_q[j]  <= t1_q[j];
    end
  end

  // stage 3: determinant partial products, row pick
  logic signed [PRW-1:0]  plo_q [3];
  logic signed [PRW-1:0]  phi_q [3];
  logic signed [ADJW-1:0] adjr_q [3];
  logic signed [ADJW-1:0] adjr_d [3];
  word_t t3_q [3];

  always_comb begin
    case (ctl_q[1].row)
      ROW0: begin
        adjr_d[0] = adj_q[0]; adjr_d[1] = adj_q[1]; adjr_d[2] = adj_q[2];
      end
      ROW1: begin
        adjr_d[0] = adj_q[3]; adjr_d[1] = adj_q[4]; adjr_d[2] = adj_q[5];
      end
      ROW2: begin
        adjr_d[0] = adj_q[6]; adjr_d[1] = adj_q[7]; adjr_d[2] = adj_q[8];
      end
      default: begin
        adjr_d[0] = adj_q[0]; adjr_d[1] = adj_q[1]; adjr_d[2] = adj_q[2];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      plo_q[j]  <= PRW'(a0b_q[j]) * PRW'($signed({1'b0, adj_q[3*j][AW-1:0]}));
      phi_q[j]  <= PRW'(a0b_q[j]) * PRW'($signed(adj_q[3*j][ADJW-1:AW]));
      adjr_q[j] <= adjr_d[j];
      t3_q[j]   <= t2_q[j];
    end
  end

  // stage 4: determinant
  logic signed [DETW-1:0] det_q;
  logic signed [ADJW-1:0] adjr4_q [3];
  word_t t4_q [3];

  always_ff @(posedge clk_i) begin
    det_q <= (DETW'(phi_q[0]) <<< AW) + DETW'(plo_q[0])
           + (DETW'(phi_q[1]) <<< AW) + DETW'(plo_q[1])
           + (DETW'(phi_q[2]) <<< AW) + DETW'(plo_q[2]);
    for (int j = 0; j < 3; j++) begin
      adjr4_q[j] <= adjr_q[j];
      t4_q[j]    <= t3_q[j];
    end
  end

  // stage 5: magnitudes, signs, singular test
  logic [DETW-1:0] absd_d;
  logic [DETW-1:0] absd_q;
  logic            sing5_q;
  logic [ADJW-1:0] absa_q [3];
  logic            neg5_q [3];
  word_t           t5_q [3];

  assign absd_d = det_q[DETW-1] ? DETW'(-det_q) : DETW'(det_q);

  always_ff @(posedge clk_i) begin
    absd_q  <= absd_d;
    sing5_q <= absd_d <= (DETW'(thr_i) << (2 * FRAC_BITS));
    for (int j = 0; j < 3; j++) begin
      absa_q[j] <= adjr4_q[j][ADJW-1] ? ADJW'(-adjr4_q[j]) : ADJW'(adjr4_q[j]);
      neg5_q[j] <= adjr4_q[j][ADJW-1] ^ det_q[DETW-1];
      t5_q[j]   <= t4_q[j];
    end
  end

  // stage 6: scaled numerators, quotient range check
  logic [NW-1:0]   n_d [3];
  logic [DETW-1:0] d6_q;
  logic            sing6_q;
  logic [NW-1:0]   n6_q [3];
  logic [1:0]      tag6_q [3];
  word_t           t6_q [3];

  always_comb begin
    for (int j = 0; j < 3; j++) n_d[j] = NW'(absa_q[j]) << (2 * FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    d6_q    <= absd_q;
    sing6_q <= sing5_q;
    for (int j = 0; j < 3; j++) begin
      n6_q[j]   <= n_d[j];
      tag6_q[j] <= {neg5_q[j], CW'(n_d[j]) >= (CW'(absd_q) << QB)};
      t6_q[j]   <= t5_q[j];
    end
  end

  assign ctl_o  = ctl_q[5];
  assign sing_o = sing6_q;
  assign d_o    = d6_q;
  assign n_o    = n6_q;
  assign tag_o  = tag6_q;
  assign t_o    = t6_q;

endmodule

[sv/affi_div_lane.sv]
module affi_div_lane
  import affi_pkg::*;
#(
  parameter int NW = 97,
  parameter int DW = 99,
  parameter int QW = 33,
  parameter int TW = 2
) (
  input  logic          clk_i,
  input  logic [NW-1:0] n_i,
  input  logic [DW-1:0] d_i,
  input  logic [TW-1:0] tag_i,
  output logic [QW-1:0] q_o,
  output logic [DW-1:0] rem_o,
  output logic [DW-1:0] d_o,
  output logic [TW-1:0] tag_o
);

  localparam int RW = (NW > DW + QW) ? NW : DW + QW;

  logic [RW-1:0] rem_w [QW+1];
  logic [DW-1:0] d_w   [QW+1];
  logic [QW-1:0] q_w   [QW+1];
  logic [TW-1:0] tag_w [QW+1];

  assign rem_w[0] = RW'(n_i);
  assign d_w[0]   = d_i;
  assign q_w[0]   = '0;
  assign tag_w[0] = tag_i;

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [RW-1:0] sub_w;
    logic          ge_w;
    logic [RW-1:0] rem_q;
    logic [DW-1:0] d_q;
    logic [QW-1:0] q_q;
    logic [TW-1:0] tag_q;

    assign sub_w = RW'(d_w[s]) << (QW - 1 - s);
    assign ge_w  = rem_w[s] >= sub_w;

    always_ff @(posedge clk_i) begin
      rem_q <= ge_w ? rem_w[s] - sub_w : rem_w[s];
      d_q   <= d_w[s];
      q_q   <= {q_w[s][QW-2:0], ge_w};
      tag_q <= tag_w[s];
    end

    assign rem_w[s+1] = rem_q;
    assign d_w[s+1]   = d_q;
    assign q_w[s+1]   = q_q;
    assign tag_w[s+1] = tag_q;
  end

  assign q_o   = q_w[QW];
  assign rem_o = rem_w[QW][DW-1:0];
  assign d_o   = d_w[QW];
  assign tag_o = tag_w[QW];

endmodule

[sv/affi_back.sv]
module affi_back
  import affi_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ctl_t            ctl_i,
  input  logic            sing_i,
  input  logic [QB-1:0]   q_i [3],
  input  logic [DETW-1:0] rem_i [3],
  input  logic [DETW-1:0] d_i,
  input  logic [1:0]      tag_i [3],
  input  word_t           t_i [3],
  output logic            valid_o,
  output logic [1:0]      row_o,
  output word_t           inv_o [3],
  output word_t           off_o,
  output logic            sing_o,
  output logic            sat_o,
  output logic            last_o
);

  localparam int QW = QB + 1;
  localparam int SW = PW + 2;
  localparam logic [QW-1:0] QLIM_POS = QW'((64'd1 << (AW - 1)) - 64'd1);
  localparam logic [QW-1:0] QLIM_NEG = QW'(64'd1 << (AW - 1));
  localparam logic [SW-1:0] SLIM_POS = SW'((64'd1 << (AW - 1)) - 64'd1);
  localparam logic [SW-1:0] SLIM_NEG = SW'(64'd1 << (AW - 1));

  ctl_t ctl_q [5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 5; i++) ctl_q[i] <= '0;
    end else begin
      ctl_q[0] <= ctl_i;
      for (int i = 1; i < 5; i++) ctl_q[i] <= ctl_q[i-1];
    end
  end

  // B1: round bit
  logic [QB-1:0] q1_q [3];
  logic          rnd1_q [3];
  logic [1:0]    tag1_q [3];
  logic          sing1_q;
  word_t         t1_q [3];

  always_ff @(posedge clk_i) begin
    sing1_q <= sing_i;
    for (int j = 0; j < 3; j++) begin
      q1_q[j]   <= q_i[j];
      rnd1_q[j] <= {rem_i[j], 1'b0} >= {1'b0, d_i};
      tag1_q[j] <= tag_i[j];
      t1_q[j]   <= t_i[j];
    end
  end

  // B2: round, clamp, sign
  logic [QW-1:0] qr_d  [3];
  logic [QW-1:0] lim_d [3];
  logic [QW-1:0] mag_d [3];
  logic          s_d   [3];
  word_t         inv_d [3];
  word_t         inv2_q [3];
  logic          sat2_q;
  logic          sing2_q;
  word_t         t2_q [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      qr_d[j]  = {1'b0, q1_q[j]} + QW'(rnd1_q[j]);
      lim_d[j] = tag1_q[j][1] ? QLIM_NEG : QLIM_POS;
      s_d[j]   = tag1_q[j][0] | (qr_d[j] > lim_d[j]);
      mag_d[j] = s_d[j] ? lim_d[j] : qr_d[j];
      inv_d[j] = tag1_q[j][1] ? -$signed(mag_d[j][AW-1:0]) : $signed(mag_d[j][AW-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    sat2_q  <= s_d[0] | s_d[1] | s_d[2];
    sing2_q <= sing1_q;
    for (int j = 0; j < 3; j++) begin
      inv2_q[j] <= inv_d[j];
      t2_q[j]   <= t1_q[j];
    end
  end

  // B3: offset products
  logic signed [PW-1:0] prod3_q [3];
  word_t inv3_q [3];
  logic  sat3_q;
  logic  sing3_q;

  always_ff @(posedge clk_i) begin
    sat3_q  <= sat2_q;
    sing3_q <= sing2_q;
    for (int j = 0; j < 3; j++) begin
      prod3_q[j] <= PW'(inv2_q[j]) * PW'(t2_q[j]);
      inv3_q[j]  <= inv2_q[j];
    end
  end

  // B4: offset sum
  logic signed [SW-1:0] sum4_q;
  word_t inv4_q [3];
  logic  sat4_q;
  logic  sing4_q;

  always_ff @(posedge clk_i) begin
    sum4_q  <= SW'(prod3_q[0]) + SW'(prod3_q[1]) + SW'(prod3_q[2]);
    sat4_q  <= sat3_q;
    sing4_q <= sing3_q;
    for (int j = 0; j < 3; j++) inv4_q[j] <= inv3_q[j];
  end

  // B5: offset = round(-sum / 2^F), clamp, output register
  logic [SW-1:0] u_d;
  logic [SW-1:0] oq_d;
  logic [SW-1:0] olim_d;
  logic          oneg_d;
  logic          osat_d;
  logic [SW-1:0] omag_d;
  word_t         off_d;

  always_comb begin
    oneg_d = !sum4_q[SW-1];
    u_d    = sum4_q[SW-1] ? SW'(-sum4_q) : SW'(sum4_q);
    oq_d   = (u_d >> FRAC_BITS) + SW'(u_d[FRAC_BITS-1]);
    olim_d = oneg_d ? SLIM_NEG : SLIM_POS;
    osat_d = oq_d > olim_d;
    omag_d = osat_d ? olim_d : oq_d;
    off_d  = oneg_d ? -$signed(omag_d[AW-1:0]) : $signed(omag_d[AW-1:0]);
  end

  word_t inv5_q [3];
  word_t off5_q;
  logic  sing5_q;
  logic  sat5_q;

  always_ff @(posedge clk_i) begin
    sing5_q <= sing4_q;
    sat5_q  <= (sat4_q | osat_d) & !sing4_q;
    off5_q  <= sing4_q ? '0 : off_d;
    for (int j = 0; j < 3; j++) inv5_q[j] <= sing4_q ? '0 : inv4_q[j];
  end

  assign valid_o = ctl_q[4].valid;
  assign row_o   = ctl_q[4].row;
  assign last_o  = ctl_q[4].row == ROW_LAST;
  assign inv_o   = inv5_q;
  assign off_o   = off5_q;
  assign sing_o  = sing5_q;
  assign sat_o   = sat5_q;

endmodule

[sv/affine3_transform_inverse.sv]
// Inverse of a 3x3 affine transform, signed fixed point with FRAC_BITS
// fraction bits.
// Input: an item (a00..a22, t0..t2) is taken at a clock edge where start_i
// is high and busy_o is low. busy_o then stays high until the item issues
// its row 2, so no new item enters before the last has issued all rows.
// Output: each item gives three rows, row 0, 1, 2, in consecutive cycles,
// each shown for one cycle with valid_o high; last_o marks row 2. The
// receiver cannot hold results off and none is needed: the row rate equals
// the output rate.
// Pipeline: 6 front stages for adjugate and determinant, 33 restoring
// divider stages, one per quotient bit, and 5 stages for rounding and the
// offset; rows 1 and 2 follow row 0.
// The item rate is set by the single result channel that the rows share.
// Configuration: cfg_we_i writes cfg_wdata_i into the singular threshold;
// change it only while no item is in flight.
// Reset: clears the threshold and all valid bits; no result is lost or
// repeated at any input pattern.
module affine3_transform_inverse
  import affi_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  logic            cfg_we_i,
  input  logic [THRW-1:0] cfg_wdata_i,
  input  logic [31:0]     a00_i,
  input  logic [31:0]     a01_i,
  input  logic [31:0]     a02_i,
  input  logic [31:0]     a10_i,
  input  logic [31:0]     a11_i,
  input  logic [31:0]     a12_i,
  input  logic [31:0]     a20_i,
  input  logic [31:0]     a21_i,
  input  logic [31:0]     a22_i,
  input  logic [31:0]     t0_i,
  input  logic [31:0]     t1_i,
  input  logic [31:0]     t2_i,
  output logic            valid_o,
  output logic [1:0]      row_index_o,
  output logic signed [31:0] inv_c0_o,
  output logic signed [31:0] inv_c1_o,
  output logic signed [31:0] inv_c2_o,
  output logic signed [31:0] new_offset_o,
  output logic            singular_o,
  output logic            saturated_o,
  output logic            last_o
);

  localparam int NW = ADJW + 2 * FRAC_BITS;

  logic            accept;
  logic [THRW-1:0] thr_q;
  ctl_t            ctl0_q;
  word_t           a_q [9];
  word_t           t_q [3];

  assign accept = start_i & ~busy_o;
  assign busy_o = ctl0_q.valid & (ctl0_q.row != ROW_LAST);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl0_q <= '0;
    end else if (accept) begin
      ctl0_q <= '{valid: 1'b1, row: ROW0};
    end else if (ctl0_q.valid && ctl0_q.row != ROW_LAST) begin
      ctl0_q.row <= ctl0_q.row + 2'd1;
    end else begin
      ctl0_q.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q <= '{a00_i, a01_i, a02_i, a10_i, a11_i, a12_i, a20_i, a21_i, a22_i};
      t_q <= '{t0_i, t1_i, t2_i};
    end
  end

  ctl_t            f_ctl;
  logic            f_sing;
  logic [DETW-1:0] f_d;
  logic [NW-1:0]   f_n [3];
  logic [1:0]      f_tag [3];
  word_t           f_t [3];

  affi_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl0_q),
    .a_i    (a_q),
    .t_i    (t_q),
    .thr_i  (thr_q),
    .ctl_o  (f_ctl),
    .sing_o (f_sing),
    .d_o    (f_d),
    .n_o    (f_n),
    .tag_o  (f_tag),
    .t_o    (f_t)
  );

  logic [QB-1:0]   l_q   [3];
  logic [DETW-1:0] l_rem [3];
  logic [DETW-1:0] l_d;
  logic [1:0]      l_tag [3];

  for (genvar j = 0; j < 3; j++) begin : g_lane
    if (j == 0) begin : g_first
      affi_div_lane #(
        .NW(NW), .DW(DETW), .QW(QB), .TW(2)
      ) u_lane (
        .clk_i (clk_i),
        .n_i   (f_n[j]),
        .d_i   (f_d),
        .tag_i (f_tag[j]),
        .q_o   (l_q[j]),
        .rem_o (l_rem[j]),
        .d_o   (l_d),
        .tag_o (l_tag[j])
      );
    end else begin : g_other
      affi_div_lane #(
        .NW(NW), .DW(DETW), .QW(QB), .TW(2)
      ) u_lane (
        .clk_i (clk_i),
        .n_i   (f_n[j]),
        .d_i   (f_d),
        .tag_i (f_tag[j]),
        .q_o   (l_q[j]),
        .rem_o (l_rem[j]),
        .d_o   (),
        .tag_o (l_tag[j])
      );
    end
  end

  // side data that rides alongside the divider
  ctl_t  ctl_dl_q  [QB];
  logic  sing_dl_q [QB];
  word_t t_dl_q    [QB][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QB; i++) ctl_dl_q[i] <= '0;
    end else begin
      ctl_dl_q[0] <= f_ctl;
      for (int i = 1; i < QB; i++) ctl_dl_q[i] <= ctl_dl_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    sing_dl_q[0] <= f_sing;
    t_dl_q[0]    <= f_t;
    for (int i = 1; i < QB; i++) begin
      sing_dl_q[i] <= sing_dl_q[i-1];
      t_dl_q[i]    <= t_dl_q[i-1];
    end
  end

  word_t b_inv [3];
  word_t b_off;

  affi_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_dl_q[QB-1]),
    .sing_i  (sing_dl_q[QB-1]),
    .q_i     (l_q),
    .rem_i   (l_rem),
    .d_i     (l_d),
    .tag_i   (l_tag),
    .t_i     (t_dl_q[QB-1]),
    .valid_o (valid_o),
    .row_o   (row_index_o),
    .inv_o   (b_inv),
    .off_o   (b_off),
    .sing_o  (singular_o),
    .sat_o   (saturated_o),
    .last_o  (last_o)
  );

  assign inv_c0_o     = b_inv[0];
  assign inv_c1_o     = b_inv[1];
  assign inv_c2_o     = b_inv[2];
  assign new_offset_o = b_off;

  a_busy_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o ##1 busy_o ##1 !busy_o)
    else $error("busy window after take is not two cycles");

  a_rows_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |=> valid_o && row_index_o == $past(row_index_o) + 2'd1)
    else $error("rows of an item not consecutive");

  a_first_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !$past(valid_o) |-> row_index_o == ROW0)
    else $error("item output does not start at row 0");

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && singular_o |-> !saturated_o && new_offset_o == 0 && inv_c0_o == 0)
    else $error("singular row carries data");

endmodule

[sim/affine3_transform_inverse_tb.sv]
`timescale 1ns / 1ps

module affine3_transform_inverse_tb;
  import affi_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [1:0] row;
    word_t      c0, c1, c2, off;
    logic       sing, sat, last;
  } inv_row_t;

  class inverse_scoreboard;
    inv_row_t   rows_q[$];
    logic [30:0] thr;
    int         errors;

    function new();
      thr = '0;
      errors = 0;
    endfunction

    function word_t div_round(input wide_t n, input wide_t d, inout bit sat);
      logic [127:0] un, ud, q, r, lim;
      bit neg;
      neg = n[127] ^ d[127];
      un = n[127] ? -n : n;
      ud = d[127] ? -d : d;
      q = un / ud;
      r = un % ud;
      if ((r << 1) >= ud) q = q + 1;
      lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
      if (q > lim) begin
        sat = 1'b1;
        q = lim;
      end
      div_round = neg ? word_t'(-q) : word_t'(q);
    endfunction

    function void note_item(input word_t m[9], input word_t t[3]);
      wide_t a[9], v[3], adj[9], det, lim, sum, absd;
      word_t inv[3];
      bit sing, sat;
      inv_row_t e;
      for (int k = 0; k < 9; k++) a[k] = m[k];
      for (int k = 0; k < 3; k++) v[k] = t[k];
      adj[0] = a[4] * a[8] - a[7] * a[5];
      adj[1] = a[2] * a[7] - a[1] * a[8];
      adj[2] = a[1] * a[5] - a[2] * a[4];
      adj[3] = a[5] * a[6] - a[3] * a[8];
      adj[4] = a[0] * a[8] - a[2] * a[6];
      adj[5] = a[2] * a[3] - a[0] * a[5];
      adj[6] = a[3] * a[7] - a[6] * a[4];
      adj[7] = a[1] * a[6] - a[0] * a[7];
      adj[8] = a[0] * a[4] - a[1] * a[3];
      det = a[0] * adj[0] + a[1] * adj[3] + a[2] * adj[6];
      lim = wide_t'({97'd0, thr}) <<< 32;
      absd = det[127] ? -det : det;
      sing = absd <= lim;
      for (int i = 0; i < 3; i++) begin
        sat = 1'b0;
        e.row = i[1:0];
        e.sing = sing;
        e.last = (i == 2);
        if (sing) begin
          e.c0 = '0; e.c1 = '0; e.c2 = '0; e.off = '0;
        end else begin
          sum = '0;
          for (int j = 0; j < 3; j++) begin
            inv[j] = div_round(adj[i*3+j] <<< 32, det, sat);
            sum = sum + wide_t'(inv[j]) * v[j];
          end
          e.c0 = inv[0]; e.c1 = inv[1]; e.c2 = inv[2];
          e.off = div_round(-sum, wide_t'(65536), sat);
        end
        e.sat = sat;
        rows_q.push_back(e);
      end
    endfunction

    function void check_row(input inv_row_t got);
      inv_row_t e;
      if (rows_q.size() == 0) begin
        $error("unexpected row %0d", got.row);
        errors++;
        return;
      end
      e = rows_q.pop_front();
      if (got.row !== e.row) begin
        $error("row_index exp %0d got %0d", e.row, got.row); errors++;
      end
      if (got.c0 !== e.c0) begin
        $error("inv_c0 exp %0d got %0d", e.c0, got.c0); errors++;
      end
      if (got.c1 !== e.c1) begin
        $error("inv_c1 exp %0d got %0d", e.c1, got.c1); errors++;
      end
      if (got.c2 !== e.c2) begin
        $error("inv_c2 exp %0d got %0d", e.c2, got.c2); errors++;
      end
      if (got.off !== e.off) begin
        $error("new_offset exp %0d got %0d", e.off, got.off); errors++;
      end
      if (got.sing !== e.sing) begin
        $error("singular exp %0d got %0d", e.sing, got.sing); errors++;
      end
      if (got.sat !== e.sat) begin
        $error("saturated exp %0d got %0d", e.sat, got.sat); errors++;
      end
      if (got.last !== e.last) begin
        $error("last exp %0d got %0d", e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [THRW-1:0] cfg_wdata_i = '0;
  logic [31:0] a_i [9];
  logic [31:0] t_i [3];
  logic busy_o, valid_o, singular_o, saturated_o, last_o;
  logic [1:0] row_index_o;
  logic signed [31:0] inv_c0_o, inv_c1_o, inv_c2_o, new_offset_o;

  inverse_scoreboard sb = new();
  int cycles = 0;
  bit calm = 1'b0;

  initial begin
    for (int k = 0; k < 9; k++) a_i[k] = '0;
    for (int k = 0; k < 3; k++) t_i[k] = '0;
  end

  always #1 clk_i = ~clk_i;

  affine3_transform_inverse u_top (
    .clk_i, .rst_ni, .start_i, .busy_o, .cfg_we_i, .cfg_wdata_i,
    .a00_i(a_i[0]), .a01_i(a_i[1]), .a02_i(a_i[2]),
    .a10_i(a_i[3]), .a11_i(a_i[4]), .a12_i(a_i[5]),
    .a20_i(a_i[6]), .a21_i(a_i[7]), .a22_i(a_i[8]),
    .t0_i(t_i[0]), .t1_i(t_i[1]), .t2_i(t_i[2]),
    .valid_o, .row_index_o, .inv_c0_o, .inv_c1_o, .inv_c2_o, .new_offset_o,
    .singular_o, .saturated_o, .last_o
  );

  always @(posedge clk_i) begin
    inv_row_t got;
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("tb: failure");
      $finish;
    end
    if (rst_ni && valid_o) begin
      got.row = row_index_o; got.c0 = inv_c0_o; got.c1 = inv_c1_o;
      got.c2 = inv_c2_o; got.off = new_offset_o; got.sing = singular_o;
      got.sat = saturated_o; got.last = last_o;
      sb.check_row(got);
    end
  end

  task automatic send_item(input word_t m[9], input word_t t[3]);
    for (int k = 0; k < 9; k++) a_i[k] <= m[k];
    for (int k = 0; k < 3; k++) t_i[k] <= t[k];
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    sb.note_item(m, t);
    if (!calm && $urandom_range(99) < 27) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  task automatic write_thr(input logic [30:0] v);
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.rows_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.thr = v;
  endtask

  function automatic word_t rnd_word();
    case ($urandom_range(3))
      0: rnd_word = $urandom;
      1: rnd_word = $signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff;
      2: rnd_word = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: rnd_word = $signed($urandom_range(0, 32'h3fffff)) - 32'sh1fffff;
    endcase
  endfunction

  task automatic random_item();
    word_t m[9], t[3];
    int kind;
    kind = $urandom_range(9);
    for (int k = 0; k < 3; k++) t[k] = rnd_word();
    for (int k = 0; k < 9; k++) begin
      if (kind < 6)
        m[k] = ((k % 4) == 0 ? 32'sh10000 : 0)
               + $signed($urandom_range(0, 32'h1ffff)) - 32'sh10000;
      else
        m[k] = rnd_word();
    end
    if (kind == 8)
      for (int k = 0; k < 3; k++) m[6+k] = m[k] + $signed($urandom_range(0, 6)) - 3;
    send_item(m, t);
  endtask

  task automatic directed_items();
    word_t m[9], t[3];
    word_t ex[4] = '{32'h7fffffff, 32'h80000000, 32'h00000001, 32'hffffffff};
    m = '{32'sh10000, 0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000};
    t = '{32'sh7fffffff, 32'sh80000000, 32'sh12345};
    send_item(m, t);
    m = '{32'sh20000, 0, 0, 0, -32'sh8000, 0, 0, 0, 32'sh30000};
    send_item(m, t);
    m = '{default: 0};
    send_item(m, t);
    m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
    send_item(m, t);
    m = '{32'sh1, 0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000};
    send_item(m, t);
    m = '{32'sh30000, 0, 0, 0, 32'sh30000, 0, 0, 0, 32'sh30000};
    t = '{32'sh1, 32'sh2, -32'sh1};
    send_item(m, t);
    m = '{32'sh10000, 32'sh20000, 32'sh30000, 32'sh40000, 32'sh50000,
          32'sh60000, 32'sh70000, 32'sh80000, 32'sh90000};
    send_item(m, t);
    for (int r = 0; r < 8; r++) begin
      for (int k = 0; k < 9; k++) m[k] = ex[$urandom_range(3)];
      for (int k = 0; k < 3; k++) t[k] = ex[$urandom_range(3)];
      send_item(m, t);
    end
    m = '{32'sh7fffffff, 0, 0, 0, 32'sh7fffffff, 0, 0, 0, 32'sh7fffffff};
    t = '{32'sh7fffffff, 32'sh7fffffff, 32'sh80000000};
    send_item(m, t);
    m = '{32'sh80000000, 0, 0, 0, 32'sh80000000, 0, 0, 0, 32'sh80000000};
    send_item(m, t);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_items();
    write_thr(31'h7fffffff);
    directed_items();
    write_thr(31'd1);
    for (int n = 0; n < 90; n++) random_item();
    write_thr(31'd0);
    calm = 1'b1;
    for (int n = 0; n < 80; n++) random_item();
    calm = 1'b0;
    write_thr(31'($urandom_range(0, 32'h20000)));
    for (int n = 0; n < 100; n++) random_item();
    write_thr(31'h7fffffff);
    for (int n = 0; n < 30; n++) random_item();
    write_thr(31'd0);
    for (int n = 0; n < 36; n++) random_item();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.rows_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[affine3_transform_inverse.f]
sv/affi_pkg.sv
sv/affi_front.sv
sv/affi_div_lane.sv
sv/affi_back.sv
sv/affine3_transform_inverse.sv
sim/affine3_transform_inverse_tb.sv
